// ===== rtl/rkp_pkg.sv =====
// Package for the RSA key pair core: widths shared by all modules.
// Depends on nothing.
package rkp_pkg;
  localparam int PRIME_WIDTH = 16;
  localparam int WORK_W = 2 * PRIME_WIDTH;
  localparam int OUT_W = 32;
  localparam int CNT_W = $clog2(WORK_W + 1);
  localparam logic [WORK_W-1:0] SEARCH_DIV = WORK_W'(3);

  function automatic logic [OUT_W-1:0] fit_out(logic [WORK_W-1:0] x);
    logic [WORK_W+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, x};
    return ext[OUT_W-1:0];
  endfunction
endpackage

// ===== rtl/rkp_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rkp_pkg.
module rkp_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rkp_pkg::WORK_W-1:0] op_a,
  input  logic [rkp_pkg::WORK_W-1:0] op_b,
  output logic                       done,
  output logic [rkp_pkg::WORK_W-1:0] prod
);
  import rkp_pkg::*;

  logic [WORK_W-1:0] mcand;
  logic [WORK_W-1:0] mplier;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mcand  <= op_a;
        mplier <= op_b;
        prod   <= '0;
        cnt    <= CNT_W'(WORK_W);
      end else if (busy) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/rkp_div.sv =====
// Restoring divider, one quotient bit per cycle; the divisor is never zero.
// Depends on rkp_pkg.
module rkp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rkp_pkg::WORK_W-1:0] num,
  input  logic [rkp_pkg::WORK_W-1:0] den,
  output logic                       done,
  output logic [rkp_pkg::WORK_W-1:0] quo,
  output logic [rkp_pkg::WORK_W-1:0] rem
);
  import rkp_pkg::*;

  logic [WORK_W-1:0] dsor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [WORK_W:0]   trial;
  logic [WORK_W:0]   diff;

  assign trial = {rem, quo[WORK_W-1]};
  assign diff  = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= num;
        rem  <= '0;
        dsor <= den;
        cnt  <= CNT_W'(WORK_W);
      end else if (busy) begin
        if (!diff[WORK_W]) begin
          rem <= diff[WORK_W-1:0];
          quo <= {quo[WORK_W-2:0], 1'b1};
        end else begin
          rem <= trial[WORK_W-1:0];
          quo <= {quo[WORK_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/rsa_key_pair_from_primes_core.sv =====
// RSA key pair core: modulus, coprime exponent and its inverse from two primes.
// Each item runs two multiplies and one divide to set up, then one divide per
// Euclid step of the coprime search, one divide plus one multiply per extended
// Euclid step and one final reducing divide, all on a single bit-serial
// multiplier and a single bit-serial divider; a prime below 2 ends after the modulus.
// Depends on rkp_pkg, rkp_mul and rkp_div.
module rsa_key_pair_from_primes_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_p,
  input  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_q,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rkp_pkg::OUT_W-1:0]       modulus,
  output logic [rkp_pkg::OUT_W-1:0]       exp_chosen,
  output logic [rkp_pkg::OUT_W-1:0]       exp_inverse,
  output logic                            key_found
);
  import rkp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MULN, S_MULPHI, S_START, S_CAND, S_GCD,
    S_EU, S_EUDIV, S_EUMUL, S_RED, S_DONE
  } state_t;

  state_t state;
  logic [WORK_W-1:0] p, q, n, phi, i, ga;
  logic [WORK_W-1:0] big, sml, cprev, ccur, tmp, inv;
  logic neg, found, small_in;

  logic mul_start, mul_done, div_start, div_done;
  logic [WORK_W-1:0] mul_a, mul_b, prod, div_n, div_d, quo, rem;

  rkp_mul u_mul (.clk, .rst, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
                 .done(mul_done), .prod);
  rkp_div u_div (.clk, .rst, .start(div_start), .num(div_n), .den(div_d),
                 .done(div_done), .quo, .rem);

  assign in_ready = (state == S_IDLE);
  assign small_in = (p[PRIME_WIDTH-1:1] == '0) || (q[PRIME_WIDTH-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p <= WORK_W'(prime_p);
            q <= WORK_W'(prime_q);
            mul_a <= WORK_W'(prime_p);
            mul_b <= WORK_W'(prime_q);
            mul_start <= 1'b1;
            found <= 1'b0;
            inv <= '0;
            i <= '0;
            state <= S_MULN;
          end
        end
        S_MULN: begin
          if (mul_done) begin
            n <= prod;
            if (small_in) begin
              state <= S_DONE;
            end else begin
              mul_a <= p - WORK_W'(1);
              mul_b <= q - WORK_W'(1);
              mul_start <= 1'b1;
              state <= S_MULPHI;
            end
          end
        end
        S_MULPHI: begin
          if (mul_done) begin
            phi <= prod;
            div_n <= prod;
            div_d <= SEARCH_DIV;
            div_start <= 1'b1;
            state <= S_START;
          end
        end
        S_START: begin
          if (div_done) begin
            i <= (quo == '0) ? WORK_W'(1) : quo;
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if (i >= phi) begin
            state <= S_DONE;
          end else begin
            ga <= i;
            div_n <= phi;
            div_d <= i;
            div_start <= 1'b1;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (div_done) begin
            if (rem == '0) begin
              if (ga == WORK_W'(1)) begin
                found <= 1'b1;
                big <= phi;
                sml <= i;
                cprev <= '0;
                ccur <= WORK_W'(1);
                neg <= 1'b0;
                state <= S_EU;
              end else begin
                i <= i + WORK_W'(1);
                state <= S_CAND;
              end
            end else begin
              ga <= rem;
              div_n <= ga;
              div_d <= rem;
              div_start <= 1'b1;
            end
          end
        end
        S_EU: begin
          if (sml > WORK_W'(1)) begin
            div_n <= big;
            div_d <= sml;
            div_start <= 1'b1;
            state <= S_EUDIV;
          end else if (sml == '0) begin
            inv <= '0;
            state <= S_DONE;
          end else begin
            div_n <= ccur;
            div_d <= phi;
            div_start <= 1'b1;
            state <= S_RED;
          end
        end
        S_EUDIV: begin
          if (div_done) begin
            tmp <= rem;
            mul_a <= quo;
            mul_b <= ccur;
            mul_start <= 1'b1;
            state <= S_EUMUL;
          end
        end
        S_EUMUL: begin
          if (mul_done) begin
            cprev <= ccur;
            ccur <= cprev + prod;
            big <= sml;
            sml <= tmp;
            neg <= !neg;
            state <= S_EU;
          end
        end
        S_RED: begin
          if (div_done) begin
            inv <= (neg && ccur != '0) ? phi - rem : rem;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            modulus <= fit_out(n);
            exp_chosen <= found ? fit_out(i) : '0;
            exp_inverse <= found ? fit_out(inv) : '0;
            key_found <= found;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_nokey_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_found |-> exp_chosen == '0 && exp_inverse == '0)
    else $error("result without a key carries a nonzero exponent");

  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_found |-> exp_chosen != '0)
    else $error("key flagged with a zero exponent");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the completion step");
endmodule

// ===== tb/sv/rkp_checker.sv =====
// Checker for the RSA key pair core: watches both channels, predicts each result
// from the accepted primes and compares field by field. Depends on rkp_pkg.
module rkp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_p,
  input  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_q,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rkp_pkg::OUT_W-1:0]       modulus,
  input  logic [rkp_pkg::OUT_W-1:0]       exp_chosen,
  input  logic [rkp_pkg::OUT_W-1:0]       exp_inverse,
  input  logic                            key_found,
  output int                              fail_count,
  output int                              keys_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] chosen;
    logic [31:0] inverse;
    logic        found;
  } key_t;

  key_t key_queue[$];

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    if (a == 0) return b;
    r = b % a;
    while (r != 0) begin
      b = a;
      a = r;
      r = b % a;
    end
    return a;
  endfunction

  function automatic logic [63:0] inverse_of(logic [63:0] v, logic [63:0] m);
    logic [63:0] big, sml, cprev, ccur, quo, rem, cnext;
    bit neg;
    big = m; sml = v; cprev = 0; ccur = 1; neg = 0;
    while (sml > 1) begin
      quo = big / sml;
      rem = big - quo * sml;
      cnext = cprev + quo * ccur;
      big = sml;
      sml = rem;
      cprev = ccur;
      ccur = cnext;
      neg = !neg;
    end
    if (sml == 0) return 0;
    if (neg && ccur != 0) return m - (ccur % m);
    return ccur % m;
  endfunction

  function automatic key_t derive_key(logic [63:0] p, logic [63:0] q);
    key_t k;
    logic [63:0] phi, start, i, prod;
    k = '0;
    prod = p * q;
    k.modulus = prod[31:0];
    if (p >= 2 && q >= 2) begin
      phi = (p - 1) * (q - 1);
      start = phi / 3;
      if (start < 1) start = 1;
      for (i = start; i < phi; i++) begin
        if (gcd64(i, phi) == 1) begin
          prod = inverse_of(i, phi);
          k.chosen = i[31:0];
          k.inverse = prod[31:0];
          k.found = 1'b1;
          break;
        end
      end
    end
    return k;
  endfunction

  always @(posedge clk) begin
    key_t exp_k;
    if (rst) begin
      fail_count <= 0;
      keys_pending <= 0;
    end else begin
      if (in_valid && in_ready) key_queue.push_back(derive_key(64'(prime_p), 64'(prime_q)));
      if (out_valid && out_ready) begin
        if (key_queue.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result transfer at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_k = key_queue.pop_front();
          if (exp_k.modulus !== modulus || exp_k.chosen !== exp_chosen ||
              exp_k.inverse !== exp_inverse || exp_k.found !== key_found) begin
            if (fail_count < 10)
              $display({"Key mismatch: expected n=%0d e=%0d d=%0d f=%0d, ",
                        "got n=%0d e=%0d d=%0d f=%0d"},
                       exp_k.modulus, exp_k.chosen, exp_k.inverse, exp_k.found,
                       modulus, exp_chosen, exp_inverse, key_found);
            fail_count <= fail_count + 1;
          end
        end
      end
      keys_pending <= key_queue.size();
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the RSA key pair core: drives primes with random gaps and
// stalls, and gives the verdict. Depends on rkp_pkg, rkp_checker and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_p = '0;
  logic [rkp_pkg::PRIME_WIDTH-1:0] prime_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rkp_pkg::OUT_W-1:0] modulus, exp_chosen, exp_inverse;
  logic key_found;
  int fail_count, keys_pending;
  bit stim_done = 0;
  bit no_idle = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rsa_key_pair_from_primes_core u_top (.*);
  rkp_checker u_chk (.*);

  task automatic send_pair(logic [15:0] p, logic [15:0] q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    prime_p <= p;
    prime_q <= q;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (!out_ready) begin
        stall = no_idle ? 0 : $urandom_range(0, 14);
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end else if (out_valid) begin
        out_ready <= 1'b0;
      end
    end
  end

  function automatic logic [15:0] draw_prime_ish();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 200));
    if (r < 8) return 16'($urandom_range(0, 3000));
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] dp[] = '{0, 1, 2, 3, 2, 65535, 65535, 65521, 3, 5, 11, 0, 65535};
    logic [15:0] dq[] = '{0, 5, 2, 3, 65535, 65535, 1, 65521, 7, 5, 13, 65535, 2};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dp[i]) send_pair(dp[i], dq[i]);
    send_pair(16'h5555, 16'haaaa);
    send_pair(16'haaaa, 16'h5555);
    in_valid <= 1'b0;
    while (keys_pending != 0) @(negedge clk);
    no_idle = 1;
    for (int i = 0; i < 40; i++) send_pair(draw_prime_ish(), draw_prime_ish());
    no_idle = 0;
    for (int i = 0; i < 260; i++) send_pair(draw_prime_ish(), draw_prime_ish());
    in_valid <= 1'b0;
    while (keys_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
